[design/bmwoe_pkg.sv]
`default_nettype none

package bmwoe_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int ACT_W     = 2;
    localparam int CAP_W     = 5;
    localparam int OUT_CNT_W = 5;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [ACT_W-1:0] ACT_GET    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUT    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        logic                 found;
        logic                 evicted;
        logic [KEY_W-1:0]     evicted_key;
        logic [OUT_CNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic             free_f;
        logic [IDX_W-1:0] free_idx;
        logic             old_f;
        logic [IDX_W-1:0] old_idx;
    } scan_stat_t;

endpackage

`default_nettype wire

[design/bmwoe_store.sv]
`default_nettype none

module bmwoe_store
    import bmwoe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             key_we,
    input  wire logic [IDX_W-1:0] key_waddr,
    input  wire logic [KEY_W-1:0] key_wdata,
    input  wire logic [IDX_W-1:0] key_raddr,
    output logic      [KEY_W-1:0] key_rdata,
    input  wire logic             val_we,
    input  wire logic [IDX_W-1:0] val_waddr,
    input  wire logic [VAL_W-1:0] val_wdata,
    input  wire logic [IDX_W-1:0] val_raddr,
    output logic      [VAL_W-1:0] val_rdata
);

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [VAL_W-1:0] val_mem [ENTRIES];
    logic [KEY_W-1:0] key_rdata_reg;
    logic [VAL_W-1:0] val_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata_reg <= val_mem[val_raddr];
    end

    assign key_rdata = key_rdata_reg;
    assign val_rdata = val_rdata_reg;

endmodule

`default_nettype wire

[design/bmwoe_match.sv]
`default_nettype none

module bmwoe_match
    import bmwoe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             init,
    input  wire logic             eval,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic             slot_valid,
    input  wire logic [IDX_W-1:0] slot_rank,
    input  wire logic [KEY_W-1:0] rd_key,
    input  wire logic [KEY_W-1:0] target_key,
    output scan_stat_t            stat
);

    scan_stat_t stat_reg;
    scan_stat_t stat_next;
    logic       key_eq;

    assign key_eq = (rd_key == target_key);

    always_comb
    begin
        stat_next = stat_reg;
        if (init)
        begin
            stat_next.hit    = 1'b0;
            stat_next.free_f = 1'b0;
            stat_next.old_f  = 1'b0;
        end
        else if (eval)
        begin
            if (!stat_reg.hit && slot_valid && key_eq)
            begin
                stat_next.hit      = 1'b1;
                stat_next.hit_idx  = idx;
                stat_next.hit_rank = slot_rank;
            end
            if (!stat_reg.free_f && !slot_valid)
            begin
                stat_next.free_f   = 1'b1;
                stat_next.free_idx = idx;
            end
            if (!stat_reg.old_f && slot_valid && (slot_rank == '0))
            begin
                stat_next.old_f   = 1'b1;
                stat_next.old_idx = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else
        begin
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule

`default_nettype wire

[design/bounded_map_write_order_evict.sv]
// Channel    | Signals                       | Transfer
// -----------+-------------------------------+-----------------------------------
// command    | start, busy, cmd              | start high while busy is low
// result     | done, rsp                     | done high for one cycle
// config     | cfg_valid, cfg_ready, cfg_data| cfg_valid and cfg_ready both high
//
// Each transaction scans all ENTRIES key slots through the single key read port and the
// one shared key comparator.
// The result strobe follows the last busy cycle; busy then stays low until the next start.
// Reset clears the valid bits, write-order ranks, entry count and capacity to 16.
// The receiver cannot stall, so results are never held back.
`default_nettype none

module bounded_map_write_order_evict
    import bmwoe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cmd_t             cmd,
    output logic                  done,
    output rsp_t                  rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_EVICT  = 3'd4;
    localparam logic [2:0] ST_INSERT = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             issue_reg, issue_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    cmd_t             cmd_reg, cmd_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0] rank_reg [ENTRIES];
    logic [IDX_W-1:0] rank_next [ENTRIES];
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;

    logic             key_we, val_we, match_init;
    logic [IDX_W-1:0] key_waddr, key_raddr, val_waddr, val_raddr;
    logic [VAL_W-1:0] val_wdata;
    logic [KEY_W-1:0] key_rdata;
    logic [VAL_W-1:0] val_rdata;
    scan_stat_t       stat;

    logic [CMP_W-1:0] cap_ext, cap_eff, held_ext;
    logic [IDX_W-1:0] ins_slot;
    logic             ins_ok;

    bmwoe_store u_store (
        .clk       (clk),
        .key_we    (key_we),
        .key_waddr (key_waddr),
        .key_wdata (cmd_reg.key),
        .key_raddr (key_raddr),
        .key_rdata (key_rdata),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata)
    );

    bmwoe_match u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (match_init),
        .eval       (issue_reg),
        .idx        (idx_reg),
        .slot_valid (valid_reg[idx_reg]),
        .slot_rank  (rank_reg[idx_reg]),
        .rd_key     (key_rdata),
        .target_key (cmd_reg.key),
        .stat       (stat)
    );

    always_comb
    begin
        cap_ext  = CMP_W'(cap_reg);
        held_ext = CMP_W'(held_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    always_comb
    begin
        if (rsp_reg.evicted && (!stat.free_f || (stat.old_idx < stat.free_idx)))
        begin
            ins_slot = stat.old_idx;
            ins_ok   = 1'b1;
        end
        else
        begin
            ins_slot = stat.free_idx;
            ins_ok   = stat.free_f;
        end
    end

    assign cap_next = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        issue_next = 1'b0;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        held_next  = held_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        key_we     = 1'b0;
        val_we     = 1'b0;
        match_init = 1'b0;
        key_waddr  = ins_slot;
        key_raddr  = stat.old_idx;
        val_waddr  = ins_slot;
        val_wdata  = cmd_reg.value;
        val_raddr  = stat.hit_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    cnt_next   = '0;
                    match_init = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                key_raddr = cnt_reg[IDX_W-1:0];
                idx_next  = cnt_reg[IDX_W-1:0];
                if (cnt_reg != CNT_W'(ENTRIES))
                begin
                    issue_next = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                rsp_next = '0;
                case (cmd_reg.action)
                    ACT_GET:
                    begin
                        rsp_next.found = stat.hit;
                        if (stat.hit)
                        begin
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_PUT:
                    begin
                        if (stat.hit)
                        begin
                            rsp_next.found = 1'b1;
                            val_we         = 1'b1;
                            val_waddr      = stat.hit_idx;
                            for (int i = 0; i < ENTRIES; i++)
                            begin
                                if (valid_reg[i] && (rank_reg[i] > stat.hit_rank))
                                begin
                                    rank_next[i] = rank_reg[i] - IDX_W'(1);
                                end
                            end
                            rank_next[stat.hit_idx] = IDX_W'(held_reg - CNT_W'(1));
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if ((held_ext >= cap_eff) && stat.old_f)
                        begin
                            state_next = ST_EVICT;
                        end
                        else
                        begin
                            state_next = ST_INSERT;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (stat.hit)
                        begin
                            rsp_next.found = 1'b1;
                            valid_next[stat.hit_idx] = 1'b0;
                            for (int i = 0; i < ENTRIES; i++)
                            begin
                                if (valid_reg[i] && (rank_reg[i] > stat.hit_rank))
                                begin
                                    rank_next[i] = rank_reg[i] - IDX_W'(1);
                                end
                            end
                            rank_next[stat.hit_idx] = '0;
                            if (held_reg != '0)
                            begin
                                held_next = held_reg - CNT_W'(1);
                            end
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        valid_next = '0;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            rank_next[i] = '0;
                        end
                        held_next  = '0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FETCH:
            begin
                rsp_next.read_value = val_rdata;
                done_next           = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_EVICT:
            begin
                rsp_next.evicted     = 1'b1;
                rsp_next.evicted_key = key_rdata;
                valid_next[stat.old_idx] = 1'b0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] != '0))
                    begin
                        rank_next[i] = rank_reg[i] - IDX_W'(1);
                    end
                end
                rank_next[stat.old_idx] = '0;
                if (held_reg != '0)
                begin
                    held_next = held_reg - CNT_W'(1);
                end
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                if (ins_ok)
                begin
                    key_we               = 1'b1;
                    val_we               = 1'b1;
                    valid_next[ins_slot] = 1'b1;
                    rank_next[ins_slot]  = IDX_W'(held_reg);
                    held_next            = held_reg + CNT_W'(1);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.entry_count = OUT_CNT_W'(held_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            issue_reg <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= '0;
            held_reg  <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            issue_reg <= issue_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            held_reg  <= held_next;
            cap_reg   <= cap_next;
            done_reg  <= done_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

[design/bmwoe_checker.sv]
`default_nettype none

module bmwoe_checker
    import bmwoe_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);

    // A transaction that is taken makes the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result is only shown once the block has gone idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // The table never reports more entries than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.entry_count <= OUT_CNT_W'(ENTRIES)))
        else $error("entry count above table size");

    // An eviction only follows an insert of a new key.
    a_evict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.evicted) |-> (!rsp.found && (rsp.read_value == '0)))
        else $error("eviction reported with a hit");

endmodule

bind bounded_map_write_order_evict bmwoe_checker u_bmwoe_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

[tb/sv/tb_bounded_map_write_order_evict.sv]
`timescale 1ns / 100ps

module tb_bounded_map_write_order_evict
    import bmwoe_pkg::*;
();

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 40;
    localparam int POOL_SIZE    = 20;
    localparam int BLOCK_ITEMS  = 50;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             done;
    rsp_t             rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    logic [KEY_W-1:0] tbl_key [ENTRIES];
    logic [VAL_W-1:0] tbl_val [ENTRIES];
    bit               tbl_live [ENTRIES];
    int               tbl_age [ENTRIES];
    int               tbl_count;
    logic [CAP_W-1:0] cap_setting;

    rsp_t             rsp_q[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               idle_pct;
    int               err_cnt;
    int               quiet_cycles;

    bounded_map_write_order_evict u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void age_close(int r);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_live[i] && tbl_age[i] > r)
                tbl_age[i]--;
        end
    endfunction

    function automatic void slot_drop(int s);
        tbl_live[s] = 1'b0;
        age_close(tbl_age[s]);
        tbl_age[s] = 0;
        if (tbl_count > 0)
            tbl_count--;
    endfunction

    function automatic rsp_t table_apply(cmd_t c);
        rsp_t r;
        int   eff_cap;
        int   hit;
        int   slot;
        r = '0;
        if (cap_setting == 0)
            eff_cap = 1;
        else if (cap_setting > ENTRIES)
            eff_cap = ENTRIES;
        else
            eff_cap = int'(cap_setting);
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && tbl_live[i] && tbl_key[i] == c.key)
                hit = i;
        end
        case (c.action)
            ACT_GET:
            begin
                if (hit >= 0)
                begin
                    r.found      = 1'b1;
                    r.read_value = tbl_val[hit];
                end
            end
            ACT_PUT:
            begin
                if (hit >= 0)
                begin
                    r.found      = 1'b1;
                    tbl_val[hit] = c.value;
                    age_close(tbl_age[hit]);
                    tbl_age[hit] = tbl_count - 1;
                end
                else
                begin
                    if (tbl_count >= eff_cap)
                    begin
                        slot = -1;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (slot < 0 && tbl_live[i] && tbl_age[i] == 0)
                                slot = i;
                        end
                        if (slot >= 0)
                        begin
                            r.evicted     = 1'b1;
                            r.evicted_key = tbl_key[slot];
                            slot_drop(slot);
                        end
                    end
                    slot = -1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (slot < 0 && !tbl_live[i])
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        tbl_key[slot]  = c.key;
                        tbl_val[slot]  = c.value;
                        tbl_live[slot] = 1'b1;
                        tbl_age[slot]  = tbl_count;
                        tbl_count++;
                    end
                end
            end
            ACT_REMOVE:
            begin
                if (hit >= 0)
                begin
                    r.found      = 1'b1;
                    r.read_value = tbl_val[hit];
                    slot_drop(hit);
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    tbl_live[i] = 1'b0;
                    tbl_age[i]  = 0;
                end
                tbl_count = 0;
            end
            default:
            begin
            end
        endcase
        r.entry_count = OUT_CNT_W'(tbl_count);
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic [ACT_W-1:0] a, logic [KEY_W-1:0] k,
                                      logic [VAL_W-1:0] v);
        cmd_t c;
        c.action = a;
        c.key    = k;
        c.value  = v;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c.action = ACT_PUT;
        else if (pick < 72)
            c.action = ACT_GET;
        else if (pick < 98)
            c.action = ACT_REMOVE;
        else
            c.action = ACT_CLEAR;
        if ($urandom_range(0, 9) == 0)
            c.key = {$urandom, $urandom};
        else
            c.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        c.value = {$urandom, $urandom};
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rsp_q.push_back(table_apply(c));
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_setting = cap;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_cmd(make_cmd(ACT_GET, '0, '1));
        send_cmd(make_cmd(ACT_REMOVE, '1, '0));
        send_cmd(make_cmd(ACT_CLEAR, '1, '1));
    endtask

    task automatic test_basic_ops();
        send_cmd(make_cmd(ACT_PUT, '0, '1));
        send_cmd(make_cmd(ACT_PUT, '1, '0));
        send_cmd(make_cmd(ACT_GET, '0, '0));
        send_cmd(make_cmd(ACT_GET, '1, '1));
        send_cmd(make_cmd(ACT_PUT, '0, 64'hA5A5_5A5A_0F0F_F0F0));
        send_cmd(make_cmd(ACT_REMOVE, '1, '0));
        send_cmd(make_cmd(ACT_GET, '1, '0));
        send_cmd(make_cmd(ACT_CLEAR, '0, '0));
        send_cmd(make_cmd(ACT_GET, '0, '0));
    endtask

    task automatic test_min_capacity();
        write_capacity(5'd0);
        send_cmd(make_cmd(ACT_PUT, 64'h11, 64'h1));
        send_cmd(make_cmd(ACT_PUT, 64'h22, 64'h2));
        send_cmd(make_cmd(ACT_GET, 64'h11, '0));
        write_capacity(5'd1);
        send_cmd(make_cmd(ACT_PUT, 64'h22, 64'h3));
        send_cmd(make_cmd(ACT_PUT, 64'h33, 64'h4));
    endtask

    task automatic test_capacity_lowered();
        write_capacity(CAP_RESET);
        send_cmd(make_cmd(ACT_CLEAR, '0, '0));
        for (int i = 0; i < 4; i++)
            send_cmd(make_cmd(ACT_PUT, 64'h100 + i, {$urandom, $urandom}));
        write_capacity(5'd2);
        send_cmd(make_cmd(ACT_PUT, 64'h200, {$urandom, $urandom}));
        send_cmd(make_cmd(ACT_PUT, 64'h102, {$urandom, $urandom}));
        send_cmd(make_cmd(ACT_PUT, 64'h201, {$urandom, $urandom}));
    endtask

    task automatic test_random_traffic(input int pct, input logic [CAP_W-1:0] cap_a,
                                       input logic [CAP_W-1:0] cap_b,
                                       input logic [CAP_W-1:0] cap_c);
        logic [CAP_W-1:0] caps [3];
        caps[0] = cap_a;
        caps[1] = cap_b;
        caps[2] = cap_c;
        idle_pct = pct;
        for (int b = 0; b < 3; b++)
        begin
            write_capacity(caps[b]);
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_cmd(random_cmd());
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (rsp_q.size() == 0)
            begin
                $error("unexpected result transaction");
                err_cnt++;
            end
            else
            begin
                exp_rsp = rsp_q.pop_front();
                if (rsp.read_value !== exp_rsp.read_value)
                begin
                    $error("read_value: expected %h, got %h", exp_rsp.read_value,
                           rsp.read_value);
                    err_cnt++;
                end
                if (rsp.found !== exp_rsp.found)
                begin
                    $error("found: expected %b, got %b", exp_rsp.found, rsp.found);
                    err_cnt++;
                end
                if (rsp.evicted !== exp_rsp.evicted)
                begin
                    $error("evicted: expected %b, got %b", exp_rsp.evicted, rsp.evicted);
                    err_cnt++;
                end
                if (rsp.evicted_key !== exp_rsp.evicted_key)
                begin
                    $error("evicted_key: expected %h, got %h", exp_rsp.evicted_key,
                           rsp.evicted_key);
                    err_cnt++;
                end
                if (rsp.entry_count !== exp_rsp.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", exp_rsp.entry_count,
                           rsp.entry_count);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= CAP_RESET;
        idle_pct     = 0;
        tbl_count    = 0;
        cap_setting  = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_live[i] = 1'b0;
            tbl_age[i]  = 0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_basic_ops();
        test_min_capacity();
        test_capacity_lowered();
        test_random_traffic(21, CAP_RESET, 5'd0, 5'd5);
        test_random_traffic(49, 5'd31, 5'd1, 5'd17);
        test_random_traffic(0, 5'd2, CAP_RESET, 5'd8);

        wait_results_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (err_cnt == 0 && rsp_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/bmwoe_pkg.sv
design/bmwoe_store.sv
design/bmwoe_match.sv
design/bounded_map_write_order_evict.sv
design/bmwoe_checker.sv
tb/sv/tb_bounded_map_write_order_evict.sv
